// ===== hdl/tpac_pkg.sv =====
package tpac_pkg;

    // Pixel coordinate width; frame sizes carry one more bit.
    localparam int COORD_BITS = 12;
    localparam int SIZE_W     = COORD_BITS + 1;
    localparam int FRAC_W     = 16;
    localparam int GAIN_W     = 16;

    // Error numerator magnitude, signed numerator and divisor (twice the size).
    localparam int MAG_W      = SIZE_W + FRAC_W;
    localparam int NUM_W      = MAG_W + 1;
    localparam int DIV_W      = SIZE_W + 1;

    localparam int ERR_W      = 17;
    localparam int SUM_W      = 24;
    localparam int DIFF_W     = ERR_W + 1;

    // Shared signed multiplier operands and product.
    localparam int MA_W       = 31;
    localparam int MB_W       = 17;
    localparam int PROD_W     = MA_W + MB_W;

    // PID accumulator, and the range it is held to before scaling.
    localparam int ACC_W      = 42;
    localparam int SAT_W      = 30;
    localparam int FRAC_SH    = 27;

    localparam int ANGLE_W    = 8;
    localparam int PSTEP_W    = 5;
    localparam int TSTEP_W    = 9;

    localparam int POS_MAX    = 180;
    localparam int PAN_RESET  = 155;
    localparam int TILT_RESET = 92;
    localparam int PAN_HOME   = 155;
    localparam int TILT_HOME  = 90;
    localparam int PAN_SCALE  = 90;
    localparam int TILT_SCALE = 80;
    localparam int PAN_LIMIT  = 10;
    localparam int TILT_LIMIT = 180;

    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = 3;
    localparam int PADDR_W    = REG_IDX_W + 2;
    localparam int PDATA_W    = 32;

    typedef enum logic [REG_IDX_W-1:0] {
        CFG_PAN_KP  = 3'd0,
        CFG_PAN_KI  = 3'd1,
        CFG_PAN_KD  = 3'd2,
        CFG_TILT_KP = 3'd3,
        CFG_TILT_KI = 3'd4,
        CFG_TILT_KD = 3'd5,
        CFG_AIM_X   = 3'd6,
        CFG_AIM_Y   = 3'd7
    } t_cfg_idx;

    localparam logic [GAIN_W-1:0] CFG_RESET [NUM_REGS] = '{
        16'd1229, 16'd0, 16'd205, 16'd1638, 16'd0, 16'd410, 16'd29491, 16'd32768
    };

endpackage

// ===== hdl/tpac_if.sv =====
interface tpac_in_if;
    logic                               valid;
    logic                               ready;
    logic                               kind;
    logic [tpac_pkg::COORD_BITS-1:0]    target_col;
    logic [tpac_pkg::COORD_BITS-1:0]    target_row;
    logic [tpac_pkg::SIZE_W-1:0]        frame_width;
    logic [tpac_pkg::SIZE_W-1:0]        frame_height;

    modport source (
        output valid, kind, target_col, target_row, frame_width, frame_height,
        input  ready
    );
    modport sink (
        input  valid, kind, target_col, target_row, frame_width, frame_height,
        output ready
    );
endinterface

interface tpac_out_if;
    logic                               valid;
    logic                               ready;
    logic [tpac_pkg::ANGLE_W-1:0]       pan_angle;
    logic [tpac_pkg::ANGLE_W-1:0]       tilt_angle;
    logic signed [tpac_pkg::PSTEP_W-1:0] pan_step;
    logic signed [tpac_pkg::TSTEP_W-1:0] tilt_step;
    logic                               bad_frame;

    modport source (
        output valid, pan_angle, tilt_angle, pan_step, tilt_step, bad_frame,
        input  ready
    );
    modport sink (
        input  valid, pan_angle, tilt_angle, pan_step, tilt_step, bad_frame,
        output ready
    );
endinterface

// ===== hdl/two_axis_pd_aim_controller.sv =====
// Two-axis pan/tilt aiming controller. Each aim beat forms a normalized
// error per axis with a shared 29-step restoring divider, then runs a PID
// step on one shared 31x17 signed multiplier and moves the held servo angle.
// The input is not ready while a beat is in work, but a new beat is taken
// while the previous result still waits on the output. Gains and aim
// points are to be written over the APB port only while the block is
// idle; the block itself does not enforce this.
module two_axis_pd_aim_controller (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    tpac_in_if.sink                            i_in,
    tpac_out_if.source                         o_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tpac_pkg::PADDR_W-1:0]       paddr,
    input  logic [tpac_pkg::PDATA_W-1:0]       pwdata,
    output logic [tpac_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    localparam int Q_W      = tpac_pkg::PROD_W - tpac_pkg::FRAC_SH;
    localparam int POS_W    = tpac_pkg::ANGLE_W + 2;
    localparam int ERR_MAX  = 2 ** (tpac_pkg::ERR_W - 2) - 1;
    localparam int ERR_MIN  = -(2 ** (tpac_pkg::ERR_W - 2));
    localparam int SUM_MAX  = 2 ** (tpac_pkg::SUM_W - 1) - 1;
    localparam int SUM_MIN  = -(2 ** (tpac_pkg::SUM_W - 1));
    localparam longint SAT_MAX = 2 ** (tpac_pkg::SAT_W - 1) - 1;
    localparam longint RND_BIAS = 2 ** tpac_pkg::FRAC_SH - 1;

    typedef enum logic [3:0] {
        S_IDLE, S_NUM, S_DSTART, S_DWAIT, S_UPD, S_MP, S_MI, S_MD,
        S_SAT, S_MS, S_STEP, S_DONE
    } t_state;

    // Configuration registers.
    logic [tpac_pkg::GAIN_W-1:0] r_cfg [tpac_pkg::NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tpac_pkg::NUM_REGS; i++) begin
                r_cfg[i] <= tpac_pkg::CFG_RESET[i];
            end
        end else if (psel && penable && pwrite) begin
            r_cfg[paddr[tpac_pkg::PADDR_W-1:2]] <= pwdata[tpac_pkg::GAIN_W-1:0];
        end
    end

    assign prdata = tpac_pkg::PDATA_W'(r_cfg[paddr[tpac_pkg::PADDR_W-1:2]]);
    assign pready = 1'b1;

    t_state                               r_state;
    logic                                 r_ax;
    logic [tpac_pkg::COORD_BITS-1:0]      r_tx;
    logic [tpac_pkg::COORD_BITS-1:0]      r_ty;
    logic [tpac_pkg::SIZE_W-1:0]          r_w;
    logic [tpac_pkg::SIZE_W-1:0]          r_h;
    logic                                 r_neg;
    logic signed [tpac_pkg::ERR_W-1:0]    r_err;
    logic signed [tpac_pkg::DIFF_W-1:0]   r_diff;
    logic signed [tpac_pkg::ACC_W-1:0]    r_acc;
    logic signed [tpac_pkg::PROD_W-1:0]   r_prod;

    logic [tpac_pkg::ANGLE_W-1:0]         r_pan_pos;
    logic [tpac_pkg::ANGLE_W-1:0]         r_tilt_pos;
    logic signed [tpac_pkg::ERR_W-1:0]    r_pan_last;
    logic signed [tpac_pkg::ERR_W-1:0]    r_tilt_last;
    logic signed [tpac_pkg::SUM_W-1:0]    r_pan_sum;
    logic signed [tpac_pkg::SUM_W-1:0]    r_tilt_sum;

    logic signed [tpac_pkg::PSTEP_W-1:0]  r_pstep;
    logic signed [tpac_pkg::TSTEP_W-1:0]  r_tstep;
    logic                                 r_bad;

    logic                                 r_ovalid;
    logic [tpac_pkg::ANGLE_W-1:0]         r_o_pan;
    logic [tpac_pkg::ANGLE_W-1:0]         r_o_tilt;
    logic signed [tpac_pkg::PSTEP_W-1:0]  r_o_pstep;
    logic signed [tpac_pkg::TSTEP_W-1:0]  r_o_tstep;
    logic                                 r_o_bad;

    // Per-axis selections.
    logic [tpac_pkg::SIZE_W-1:0]          size;
    logic [tpac_pkg::COORD_BITS-1:0]      target;
    logic [tpac_pkg::FRAC_W-1:0]          frac;
    logic [tpac_pkg::GAIN_W-1:0]          kp, ki, kd;
    logic signed [tpac_pkg::SUM_W-1:0]    sum_cur;
    logic signed [tpac_pkg::ERR_W-1:0]    last_cur;
    logic [tpac_pkg::ANGLE_W-1:0]         pos_cur;

    assign size     = r_ax ? r_h : r_w;
    assign target   = r_ax ? r_ty : r_tx;
    assign frac     = r_ax ? r_cfg[tpac_pkg::CFG_AIM_Y] : r_cfg[tpac_pkg::CFG_AIM_X];
    assign kp       = r_ax ? r_cfg[tpac_pkg::CFG_TILT_KP] : r_cfg[tpac_pkg::CFG_PAN_KP];
    assign ki       = r_ax ? r_cfg[tpac_pkg::CFG_TILT_KI] : r_cfg[tpac_pkg::CFG_PAN_KI];
    assign kd       = r_ax ? r_cfg[tpac_pkg::CFG_TILT_KD] : r_cfg[tpac_pkg::CFG_PAN_KD];
    assign sum_cur  = r_ax ? r_tilt_sum : r_pan_sum;
    assign last_cur = r_ax ? r_tilt_last : r_pan_last;
    assign pos_cur  = r_ax ? r_tilt_pos : r_pan_pos;

    // Shared multiplier with operands chosen by the sequencer.
    logic signed [tpac_pkg::MA_W-1:0]     mul_a;
    logic signed [tpac_pkg::MB_W-1:0]     mul_b;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_NUM: begin
                mul_a = tpac_pkg::MA_W'(size);
                mul_b = tpac_pkg::MB_W'(frac);
            end
            S_MP: begin
                mul_a = tpac_pkg::MA_W'(r_err);
                mul_b = tpac_pkg::MB_W'(kp);
            end
            S_MI: begin
                mul_a = tpac_pkg::MA_W'(sum_cur);
                mul_b = tpac_pkg::MB_W'(ki);
            end
            S_MD: begin
                mul_a = tpac_pkg::MA_W'(r_diff);
                mul_b = tpac_pkg::MB_W'(kd);
            end
            S_MS: begin
                mul_a = tpac_pkg::MA_W'(r_acc);
                mul_b = r_ax ? tpac_pkg::MB_W'(tpac_pkg::TILT_SCALE)
                             : tpac_pkg::MB_W'(tpac_pkg::PAN_SCALE);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Error numerator: size * aim fraction minus target shifted into Q.16.
    logic signed [tpac_pkg::NUM_W-1:0]    num;
    logic [tpac_pkg::MAG_W-1:0]           num_mag;
    logic                                 div_start;
    logic                                 div_done;
    logic [tpac_pkg::MAG_W-1:0]           quo;

    assign num = $signed(r_prod[tpac_pkg::NUM_W-1:0])
               - $signed(tpac_pkg::NUM_W'({target, 16'h0000}));
    assign num_mag   = num[tpac_pkg::NUM_W-1] ? tpac_pkg::MAG_W'(-num)
                                              : tpac_pkg::MAG_W'(num);
    assign div_start = (r_state == S_DSTART);

    tpac_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (num_mag),
        .i_divisor  ({size, 1'b0}),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    // Signed quotient with saturation to Q1.15.
    logic signed [tpac_pkg::ERR_W-1:0]    err_c;

    always_comb begin
        if (r_neg) begin
            err_c = (quo > tpac_pkg::MAG_W'(ERR_MAX)) ? tpac_pkg::ERR_W'(ERR_MIN)
                                                      : -tpac_pkg::ERR_W'(quo);
        end else begin
            err_c = (quo > tpac_pkg::MAG_W'(ERR_MAX)) ? tpac_pkg::ERR_W'(ERR_MAX)
                                                      : tpac_pkg::ERR_W'(quo);
        end
    end

    // Saturating integral.
    logic signed [tpac_pkg::SUM_W:0]      sum_wide;
    logic signed [tpac_pkg::SUM_W-1:0]    sum_new;

    always_comb begin
        sum_wide = (tpac_pkg::SUM_W + 1)'(sum_cur) + (tpac_pkg::SUM_W + 1)'(r_err);
        if (sum_wide > (tpac_pkg::SUM_W + 1)'(SUM_MAX)) begin
            sum_new = tpac_pkg::SUM_W'(SUM_MAX);
        end else if (sum_wide < (tpac_pkg::SUM_W + 1)'(SUM_MIN)) begin
            sum_new = tpac_pkg::SUM_W'(SUM_MIN);
        end else begin
            sum_new = tpac_pkg::SUM_W'(sum_wide);
        end
    end

    // Final PID sum, held to a range past which both steps are already at
    // their limits.
    logic signed [tpac_pkg::ACC_W-1:0]    acc_fin;
    logic signed [tpac_pkg::ACC_W-1:0]    acc_sat;

    always_comb begin
        acc_fin = r_acc + $signed(r_prod[tpac_pkg::ACC_W-1:0]);
        if (acc_fin > tpac_pkg::ACC_W'(SAT_MAX)) begin
            acc_sat = tpac_pkg::ACC_W'(SAT_MAX);
        end else if (acc_fin < -tpac_pkg::ACC_W'(SAT_MAX)) begin
            acc_sat = -tpac_pkg::ACC_W'(SAT_MAX);
        end else begin
            acc_sat = acc_fin;
        end
    end

    // Scaled product to degrees, truncated toward zero, limited, and
    // applied to the held angle.
    logic signed [tpac_pkg::PROD_W-1:0]   biased;
    logic signed [Q_W-1:0]                q_deg;
    logic signed [Q_W-1:0]                lim;
    logic signed [Q_W-1:0]                step_c;
    logic signed [POS_W-1:0]              pos_sum;
    logic [tpac_pkg::ANGLE_W-1:0]         pos_new;

    always_comb begin
        biased = r_prod + (r_prod[tpac_pkg::PROD_W-1] ? tpac_pkg::PROD_W'(RND_BIAS)
                                                      : tpac_pkg::PROD_W'(0));
        q_deg  = Q_W'(biased >>> tpac_pkg::FRAC_SH);
        lim    = r_ax ? Q_W'(tpac_pkg::TILT_LIMIT) : Q_W'(tpac_pkg::PAN_LIMIT);
        if (q_deg > lim) begin
            step_c = lim;
        end else if (q_deg < -lim) begin
            step_c = -lim;
        end else begin
            step_c = q_deg;
        end
        pos_sum = $signed(POS_W'(pos_cur)) + POS_W'(step_c);
        if (pos_sum < $signed(POS_W'(0))) begin
            pos_new = '0;
        end else if (pos_sum > $signed(POS_W'(tpac_pkg::POS_MAX))) begin
            pos_new = tpac_pkg::ANGLE_W'(tpac_pkg::POS_MAX);
        end else begin
            pos_new = tpac_pkg::ANGLE_W'(pos_sum);
        end
    end

    logic in_acc;
    logic out_free;

    assign in_acc   = i_in.valid && (r_state == S_IDLE);
    assign out_free = !r_ovalid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ax        <= 1'b0;
            r_neg       <= 1'b0;
            r_err       <= '0;
            r_diff      <= '0;
            r_acc       <= '0;
            r_tx        <= '0;
            r_ty        <= '0;
            r_w         <= '0;
            r_h         <= '0;
            r_pan_pos   <= tpac_pkg::ANGLE_W'(tpac_pkg::PAN_RESET);
            r_tilt_pos  <= tpac_pkg::ANGLE_W'(tpac_pkg::TILT_RESET);
            r_pan_last  <= '0;
            r_tilt_last <= '0;
            r_pan_sum   <= '0;
            r_tilt_sum  <= '0;
            r_pstep     <= '0;
            r_tstep     <= '0;
            r_bad       <= 1'b0;
            r_ovalid    <= 1'b0;
            r_o_pan     <= '0;
            r_o_tilt    <= '0;
            r_o_pstep   <= '0;
            r_o_tstep   <= '0;
            r_o_bad     <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_pstep <= '0;
                        r_tstep <= '0;
                        r_bad   <= 1'b0;
                        r_tx    <= i_in.target_col;
                        r_ty    <= i_in.target_row;
                        r_w     <= i_in.frame_width;
                        r_h     <= i_in.frame_height;
                        r_ax    <= 1'b0;
                        if (i_in.kind) begin
                            r_pan_pos   <= tpac_pkg::ANGLE_W'(tpac_pkg::PAN_HOME);
                            r_tilt_pos  <= tpac_pkg::ANGLE_W'(tpac_pkg::TILT_HOME);
                            r_pan_last  <= '0;
                            r_tilt_last <= '0;
                            r_pan_sum   <= '0;
                            r_tilt_sum  <= '0;
                            r_state     <= S_DONE;
                        end else if (i_in.frame_width == '0 || i_in.frame_height == '0) begin
                            r_bad   <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_NUM;
                        end
                    end
                end
                S_NUM: begin
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_neg   <= num[tpac_pkg::NUM_W-1];
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (div_done) begin
                        r_err   <= err_c;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_diff <= tpac_pkg::DIFF_W'(r_err) - tpac_pkg::DIFF_W'(last_cur);
                    if (r_ax) begin
                        r_tilt_sum  <= sum_new;
                        r_tilt_last <= r_err;
                    end else begin
                        r_pan_sum   <= sum_new;
                        r_pan_last  <= r_err;
                    end
                    r_state <= S_MP;
                end
                S_MP: begin
                    r_state <= S_MI;
                end
                S_MI: begin
                    r_acc   <= $signed(r_prod[tpac_pkg::ACC_W-1:0]);
                    r_state <= S_MD;
                end
                S_MD: begin
                    r_acc   <= r_acc + $signed(r_prod[tpac_pkg::ACC_W-1:0]);
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_acc   <= acc_sat;
                    r_state <= S_MS;
                end
                S_MS: begin
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    if (r_ax) begin
                        r_tstep    <= tpac_pkg::TSTEP_W'(step_c);
                        r_tilt_pos <= pos_new;
                        r_state    <= S_DONE;
                    end else begin
                        r_pstep   <= tpac_pkg::PSTEP_W'(step_c);
                        r_pan_pos <= pos_new;
                        r_ax      <= 1'b1;
                        r_state   <= S_NUM;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_o_pan   <= r_pan_pos;
                        r_o_tilt  <= r_tilt_pos;
                        r_o_pstep <= r_pstep;
                        r_o_tstep <= r_tstep;
                        r_o_bad   <= r_bad;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_ovalid;
    assign o_out.pan_angle  = r_o_pan;
    assign o_out.tilt_angle = r_o_tilt;
    assign o_out.pan_step   = r_o_pstep;
    assign o_out.tilt_step  = r_o_tstep;
    assign o_out.bad_frame  = r_o_bad;

endmodule

// ===== hdl/tpac_div.sv =====
module tpac_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tpac_pkg::MAG_W-1:0]    i_dividend,
    input  logic [tpac_pkg::DIV_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [tpac_pkg::MAG_W-1:0]    o_quotient
);

    localparam int CNT_W = $clog2(tpac_pkg::MAG_W);

    logic [tpac_pkg::MAG_W-1:0] r_quo;
    logic [tpac_pkg::DIV_W-1:0] r_rem;
    logic [tpac_pkg::DIV_W-1:0] r_div;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [tpac_pkg::DIV_W:0]   shifted;
    logic                       fits;

    // Restoring division, one quotient bit per cycle; quotient bits shift
    // in where dividend bits shift out.
    assign shifted = {r_rem, r_quo[tpac_pkg::MAG_W-1]};
    assign fits    = shifted >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_quo  <= '0;
            r_rem  <= '0;
            r_div  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_cnt  <= CNT_W'(tpac_pkg::MAG_W - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= fits ? tpac_pkg::DIV_W'(shifted - {1'b0, r_div})
                              : shifted[tpac_pkg::DIV_W-1:0];
                r_quo <= {r_quo[tpac_pkg::MAG_W-2:0], fits};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== sim/aim_checker.sv =====
module aim_checker
    import tpac_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    tpac_in_if                 in_ch,
    tpac_out_if                out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic [PDATA_W-1:0] prdata,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     PAN_AXIS  = 0;
    localparam int     TILT_AXIS = 1;
    localparam longint ERR_HI    = 32767;
    localparam longint ERR_LO    = -32768;
    localparam longint SUM_HI    = (longint'(1) << (SUM_W - 1)) - 1;
    localparam longint SUM_LO    = -(longint'(1) << (SUM_W - 1));

    typedef struct {
        logic [ANGLE_W-1:0]        pan_angle;
        logic [ANGLE_W-1:0]        tilt_angle;
        logic signed [PSTEP_W-1:0] pan_step;
        logic signed [TSTEP_W-1:0] tilt_step;
        logic                      bad_frame;
    } t_servo_move;

    t_servo_move       moves_due [$];
    logic [GAIN_W-1:0] gain_reg [NUM_REGS];
    int                pan_pos;
    int                tilt_pos;
    longint            err_last [2];
    longint            err_sum [2];

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // Offset of the target from the aim point, as a signed fraction of the frame.
    function automatic longint norm_error(logic [COORD_BITS-1:0] tgt,
                                          logic [SIZE_W-1:0] size,
                                          logic [FRAC_W-1:0] frac);
        longint num;
        num = longint'(size) * longint'(frac) - longint'(tgt) * 65536;
        return clip(num / (2 * longint'(size)), ERR_LO, ERR_HI);
    endfunction

    function automatic longint pid_drive(int ax, longint e, logic [GAIN_W-1:0] kp,
                                         logic [GAIN_W-1:0] ki, logic [GAIN_W-1:0] kd);
        longint diff;
        err_sum[ax] = clip(err_sum[ax] + e, SUM_LO, SUM_HI);
        diff = e - err_last[ax];
        err_last[ax] = e;
        return longint'(kp) * e + longint'(ki) * err_sum[ax] + longint'(kd) * diff;
    endfunction

    function automatic void clear_axes();
        err_last[PAN_AXIS] = 0;
        err_last[TILT_AXIS] = 0;
        err_sum[PAN_AXIS] = 0;
        err_sum[TILT_AXIS] = 0;
    endfunction

    function automatic t_servo_move predict_move(logic kind,
                                                 logic [COORD_BITS-1:0] tx,
                                                 logic [COORD_BITS-1:0] ty,
                                                 logic [SIZE_W-1:0] w,
                                                 logic [SIZE_W-1:0] h);
        t_servo_move m;
        longint      pan_acc;
        longint      tilt_acc;
        longint      pstep;
        longint      tstep;
        pstep = 0;
        tstep = 0;
        m.bad_frame = 1'b0;
        if (kind) begin
            pan_pos = PAN_HOME;
            tilt_pos = TILT_HOME;
            clear_axes();
        end else if (w == 0 || h == 0) begin
            m.bad_frame = 1'b1;
        end else begin
            pan_acc = pid_drive(PAN_AXIS, norm_error(tx, w, gain_reg[CFG_AIM_X]),
                                gain_reg[CFG_PAN_KP], gain_reg[CFG_PAN_KI],
                                gain_reg[CFG_PAN_KD]);
            tilt_acc = pid_drive(TILT_AXIS, norm_error(ty, h, gain_reg[CFG_AIM_Y]),
                                 gain_reg[CFG_TILT_KP], gain_reg[CFG_TILT_KI],
                                 gain_reg[CFG_TILT_KD]);
            pstep = clip((pan_acc * PAN_SCALE) / (longint'(1) << FRAC_SH),
                         -PAN_LIMIT, PAN_LIMIT);
            tstep = clip((tilt_acc * TILT_SCALE) / (longint'(1) << FRAC_SH),
                         -TILT_LIMIT, TILT_LIMIT);
            pan_pos = int'(clip(pan_pos + pstep, 0, POS_MAX));
            tilt_pos = int'(clip(tilt_pos + tstep, 0, POS_MAX));
        end
        m.pan_angle = ANGLE_W'(pan_pos);
        m.tilt_angle = ANGLE_W'(tilt_pos);
        m.pan_step = PSTEP_W'(pstep);
        m.tilt_step = TSTEP_W'(tstep);
        return m;
    endfunction

    task automatic check_field(string field, logic signed [15:0] want,
                               logic signed [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_servo_move want;
        if (!i_rst_n) begin
            foreach (gain_reg[i]) begin
                gain_reg[i] = CFG_RESET[i];
            end
            pan_pos = PAN_RESET;
            tilt_pos = TILT_RESET;
            clear_axes();
            moves_due.delete();
            o_pending = 0;
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    gain_reg[paddr[PADDR_W-1:2]] = pwdata[GAIN_W-1:0];
                end else if (prdata !== PDATA_W'(gain_reg[paddr[PADDR_W-1:2]])) begin
                    $error("prdata mismatch at register %0d: expected %0d, got %0d",
                           paddr[PADDR_W-1:2], gain_reg[paddr[PADDR_W-1:2]], prdata);
                    o_fail_count++;
                end
            end
            if (out_ch.valid && out_ch.ready) begin
                if (moves_due.size() == 0) begin
                    $error("result beat with nothing expected: pan %0d tilt %0d",
                           out_ch.pan_angle, out_ch.tilt_angle);
                    o_fail_count++;
                end else begin
                    want = moves_due.pop_front();
                    o_checked++;
                    check_field("pan_angle", want.pan_angle, out_ch.pan_angle);
                    check_field("tilt_angle", want.tilt_angle, out_ch.tilt_angle);
                    check_field("pan_step", want.pan_step, out_ch.pan_step);
                    check_field("tilt_step", want.tilt_step, out_ch.tilt_step);
                    check_field("bad_frame", want.bad_frame, out_ch.bad_frame);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                moves_due.push_back(predict_move(in_ch.kind, in_ch.target_col,
                                                 in_ch.target_row, in_ch.frame_width,
                                                 in_ch.frame_height));
            end
            o_pending = moves_due.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tpac_pkg::*;

    localparam int LONG_HOLD = 400;

    typedef enum int {
        SET_MODERATE,
        SET_FULL,
        SET_WINDUP,
        SET_ZERO,
        SET_MAX
    } t_gain_set;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int pending;
    int checked;

    bit hold_go = 1'b0;
    bit hold_done = 1'b0;
    bit calm_tail = 1'b0;

    int beats_sent = 0;
    int homes_sent = 0;
    int zero_frames_sent = 0;
    int settings_used = 0;
    int send_calm_left = 0;
    bit send_calm = 1'b0;

    logic [GAIN_W-1:0] next_cfg [NUM_REGS];

    tpac_in_if  in_ch ();
    tpac_out_if out_ch ();

    two_axis_pd_aim_controller uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    aim_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("two_axis_pd_aim_controller test failed");
        $finish;
    end

    // Result side: short random stalls, calm stretches, and one long hold-off
    // that backs the block up into its input.
    initial begin : result_sink
        int   hold_left;
        int   stall_left;
        int   stretch_left;
        bit   stretch_calm;
        logic next_ready;
        hold_left = 0;
        stall_left = 0;
        stretch_left = 0;
        stretch_calm = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(20, 200);
                stretch_calm = ($urandom_range(0, 2) == 0);
            end
            stretch_left--;
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                next_ready = 1'b0;
            end else if (!calm_tail && !stretch_calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 3);
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
            out_ch.ready <= next_ready;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(logic kind, int tx, int ty, int w, int h);
        if (send_calm_left == 0) begin
            send_calm_left = $urandom_range(10, 60);
            send_calm = ($urandom_range(0, 2) == 0);
        end
        send_calm_left--;
        if (!calm_tail && !send_calm && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= kind;
        in_ch.target_col <= COORD_BITS'(tx);
        in_ch.target_row <= COORD_BITS'(ty);
        in_ch.frame_width <= SIZE_W'(w);
        in_ch.frame_height <= SIZE_W'(h);
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        beats_sent++;
        if (kind) begin
            homes_sent++;
        end else if (w == 0 || h == 0) begin
            zero_frames_sent++;
        end
    endtask

    task automatic apb_transfer(logic write, t_cfg_idx idx, logic [GAIN_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= {idx, 2'b00};
        pwdata <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [GAIN_W-1:0] value);
        apb_transfer(1'b1, idx, value);
    endtask

    task automatic read_all_regs();
        for (int i = 0; i < NUM_REGS; i++) begin
            apb_transfer(1'b0, t_cfg_idx'(i), '0);
        end
    endtask

    // Lower valid and wait until every expected result has been taken.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic run_setting(t_gain_set kind);
        foreach (next_cfg[i]) begin
            case (kind)
                SET_MODERATE: next_cfg[i] = GAIN_W'($urandom_range(0, 8191));
                SET_WINDUP:   next_cfg[i] = GAIN_W'($urandom_range(0, 1024));
                SET_ZERO:     next_cfg[i] = '0;
                SET_MAX:      next_cfg[i] = '1;
                default:      next_cfg[i] = GAIN_W'($urandom_range(0, 65535));
            endcase
        end
        if (kind == SET_MODERATE) begin
            next_cfg[CFG_PAN_KI] = GAIN_W'($urandom_range(0, 256));
            next_cfg[CFG_TILT_KI] = GAIN_W'($urandom_range(0, 256));
        end else if (kind == SET_WINDUP) begin
            // A tiny integral gain keeps the wound-up tilt sum visible below the tilt step clamp.
            next_cfg[CFG_PAN_KI] = GAIN_W'($urandom_range(1, 3));
            next_cfg[CFG_TILT_KI] = GAIN_W'($urandom_range(1, 3));
        end
        next_cfg[CFG_AIM_X] = GAIN_W'($urandom_range(0, 65535));
        next_cfg[CFG_AIM_Y] = GAIN_W'($urandom_range(0, 65535));
        drain();
        for (int i = 0; i < NUM_REGS; i++) begin
            write_reg(t_cfg_idx'(i), next_cfg[i]);
        end
        read_all_regs();
        settings_used++;
    endtask

    function automatic int nudge(int v);
        v = v + int'($urandom_range(0, 64)) - 32;
        if (v < 0) begin
            v = 0;
        end
        if (v > 4095) begin
            v = 4095;
        end
        return v;
    endfunction

    // Mostly a tracked target drifting over a steady frame, with homes,
    // zero frames and unconstrained beats mixed in.
    task automatic aim_phase(int count);
        int left;
        int run_len;
        int roll;
        int zero_pick;
        int w;
        int h;
        int tx;
        int ty;
        left = count;
        while (left > 0) begin
            roll = $urandom_range(0, 9);
            if (roll < 6) begin
                w = $urandom_range(160, 4096);
                h = $urandom_range(120, 4096);
            end else if (roll < 8) begin
                w = $urandom_range(1, 64);
                h = $urandom_range(1, 64);
            end else begin
                w = $urandom_range(1, 8191);
                h = $urandom_range(1, 8191);
            end
            tx = $urandom_range(0, 4095) % w;
            ty = $urandom_range(0, 4095) % h;
            run_len = $urandom_range(4, 40);
            while (run_len > 0 && left > 0) begin
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    send_beat(1'b1, $urandom_range(0, 4095), $urandom_range(0, 4095),
                              $urandom_range(0, 8191), $urandom_range(0, 8191));
                end else if (roll < 6) begin
                    zero_pick = $urandom_range(0, 2);
                    send_beat(1'b0, tx, ty, (zero_pick == 1) ? w : 0,
                              (zero_pick == 0) ? h : 0);
                end else if (roll < 10) begin
                    send_beat(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095),
                              $urandom_range(0, 8191), $urandom_range(0, 8191));
                end else begin
                    tx = nudge(tx);
                    ty = nudge(ty);
                    send_beat(1'b0, tx, ty, w, h);
                end
                run_len--;
                left--;
            end
        end
    endtask

    initial begin : stimulus
        in_ch.valid = 1'b0;
        in_ch.kind = 1'b0;
        in_ch.target_col = '0;
        in_ch.target_row = '0;
        in_ch.frame_width = '0;
        in_ch.frame_height = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        read_all_regs();

        // Directed beats on the reset gains.
        send_beat(1'b1, 4095, 4095, 8191, 8191);
        send_beat(1'b0, 320, 240, 640, 480);
        send_beat(1'b0, 0, 0, 4096, 4096);
        send_beat(1'b0, 4095, 4095, 4096, 4096);
        send_beat(1'b0, 4095, 4095, 1, 1);
        send_beat(1'b0, 0, 0, 8191, 8191);
        send_beat(1'b0, 100, 100, 0, 480);
        send_beat(1'b0, 100, 100, 640, 0);
        send_beat(1'b0, 0, 0, 0, 0);
        send_beat(1'b1, 0, 0, 0, 0);

        // Full gains with the aim point at the far edge drive both axes to the top stop.
        drain();
        write_reg(CFG_PAN_KP, '1);
        write_reg(CFG_PAN_KI, '1);
        write_reg(CFG_PAN_KD, '1);
        write_reg(CFG_TILT_KP, '1);
        write_reg(CFG_TILT_KI, '1);
        write_reg(CFG_TILT_KD, '1);
        write_reg(CFG_AIM_X, '1);
        write_reg(CFG_AIM_Y, '1);
        read_all_regs();
        settings_used++;
        repeat (3) send_beat(1'b0, 0, 0, 1, 1);

        // Aim point at zero swings both axes hard the other way.
        drain();
        write_reg(CFG_AIM_X, '0);
        write_reg(CFG_AIM_Y, '0);
        repeat (3) send_beat(1'b0, 4095, 4095, 1, 1);
        send_beat(1'b0, 2048, 2048, 4096, 4096);

        drain();
        write_reg(CFG_PAN_KP, '0);
        write_reg(CFG_PAN_KI, '0);
        write_reg(CFG_PAN_KD, '0);
        write_reg(CFG_TILT_KP, '0);
        write_reg(CFG_TILT_KI, '0);
        write_reg(CFG_TILT_KD, '0);
        read_all_regs();
        send_beat(1'b0, 1000, 500, 2000, 1000);
        send_beat(1'b1, 1000, 500, 2000, 1000);

        run_setting(SET_MODERATE);
        aim_phase(200);

        run_setting(SET_FULL);
        hold_go = 1'b1;
        aim_phase(200);

        // A long run of saturated errors winds the integral sums into their limit.
        run_setting(SET_WINDUP);
        repeat (270) begin
            send_beat(1'b0, $urandom_range(8, 4095), $urandom_range(8, 4095),
                      $urandom_range(1, 3), $urandom_range(1, 3));
        end
        aim_phase(30);

        run_setting(SET_ZERO);
        aim_phase(100);

        run_setting(SET_MAX);
        aim_phase(120);

        run_setting(SET_MODERATE);
        calm_tail = 1'b1;
        aim_phase(410);

        drain();
        repeat (100) @(negedge i_clk);
        $display("Sent %0d beats (%0d home, %0d zero-frame) over %0d gain settings,",
                 beats_sent, homes_sent, zero_frames_sent, settings_used);
        $display("with one %0d-cycle output hold-off; %0d result beats compared.",
                 LONG_HOLD, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("two_axis_pd_aim_controller test passed");
        end else begin
            $display("two_axis_pd_aim_controller test failed");
        end
        $finish;
    end

endmodule

// ===== two_axis_pd_aim_controller.f =====
hdl/tpac_pkg.sv
hdl/tpac_if.sv
hdl/tpac_div.sv
hdl/two_axis_pd_aim_controller.sv
sim/aim_checker.sv
sim/testbench.sv
